[rtl/sbs_pkg.sv]
package sbs_pkg;

    // Operation codes carried by s_operation
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Width of one stored character
    localparam int CHAR_W = 8;

endpackage

[rtl/string_bubble_sorter.sv]
// Channel   Ports                                             Direction
// -------   -----------------------------------------------   ---------
// s_        s_valid s_ready s_operation s_char_code            in
//           s_end_of_string s_end_of_set
// m_        m_valid m_ready m_out_char m_out_end_of_string      out
//           m_out_end_of_set m_valid_res m_truncated
//
// A push beat gives no result. A read beat gives one result, registered through the
// pending flag and then the output register; no new beat is taken while it is pending.
// After the last push of a set the sort walks the order table with one read and one write
// port: each neighbor compare reads the next entry, both lengths and first characters,
// then walks the common prefix. A string fetch (order read, then length read) follows
// the end of a set and each finished string on read.
// s_ready is low during the sort and fetches, for the cycle after a read beat, and while
// a result waits with m_ready low.
// aresetn is synchronous and active low; the memories keep their contents.
module string_bubble_sorter #(
    parameter int MAX_STRINGS   = 16,
    parameter int STRING_LENGTH = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_operation,
    input  logic [sbs_pkg::CHAR_W-1:0]  s_char_code,
    input  logic                        s_end_of_string,
    input  logic                        s_end_of_set,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [sbs_pkg::CHAR_W-1:0]  m_out_char,
    output logic                        m_out_end_of_string,
    output logic                        m_out_end_of_set,
    output logic                        m_valid_res,
    output logic                        m_truncated
);

    localparam int SW         = $clog2(MAX_STRINGS);
    localparam int CW         = $clog2(MAX_STRINGS + 1);
    localparam int LW         = $clog2(STRING_LENGTH);
    localparam int AW         = SW + LW;
    localparam int CHAR_DEPTH = MAX_STRINGS << LW;

    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_STRINGS);
    localparam logic [LW-1:0] MAX_POS = LW'(STRING_LENGTH - 1);

    typedef enum logic [1:0] {PH_LOADING, PH_SORTED, PH_DONE} phase_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PASS, ST_CUR, ST_NXT, ST_LENS, ST_CMP, ST_TAIL, ST_FETCH
    } state_t;

    // Memories
    logic [sbs_pkg::CHAR_W-1:0] char_mem [CHAR_DEPTH];
    logic [LW-1:0]              len_mem  [MAX_STRINGS];
    logic [SW-1:0]              ord_mem  [MAX_STRINGS];

    // Memory port signals
    logic                       char_we, char_ra_en, char_rb_en;
    logic [AW-1:0]              char_waddr, char_ra_addr, char_rb_addr;
    logic [sbs_pkg::CHAR_W-1:0] char_wdata;
    logic [sbs_pkg::CHAR_W-1:0] cha_q_reg, chb_q_reg;

    logic                       len_we, len_ra_en, len_rb_en;
    logic [SW-1:0]              len_waddr, len_ra_addr, len_rb_addr;
    logic [LW-1:0]              len_wdata;
    logic [LW-1:0]              lena_q_reg, lenb_q_reg;

    logic                       ord_we, ord_re;
    logic [SW-1:0]              ord_waddr, ord_raddr, ord_wdata;
    logic [SW-1:0]              ord_q_reg;

    // Control state
    state_t        state_reg, state_next;
    phase_t        phase_reg, phase_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [LW-1:0] pos_reg, pos_next;
    logic          ovf_reg, ovf_next;
    logic [SW-1:0] rs_reg, rs_next;
    logic [LW-1:0] rc_reg, rc_next;

    // Sort working registers
    logic [SW-1:0] pass_reg, pass_next;
    logic [SW-1:0] j_reg, j_next;
    logic [SW-1:0] cur_reg, cur_next;
    logic [SW-1:0] nxt_reg, nxt_next;
    logic [LW-1:0] i_reg, i_next;
    logic [SW-1:0] str_reg, str_next;

    // Result path
    logic          pend_reg, pend_next;
    logic          pend_eos_reg, pend_eos_next;
    logic          pend_eoset_reg, pend_eoset_next;
    logic          pend_vld_reg, pend_vld_next;
    logic          pend_trunc_reg, pend_trunc_next;
    logic          m_valid_reg, m_valid_next;
    logic [sbs_pkg::CHAR_W-1:0] m_char_reg, m_char_next;
    logic          m_eos_reg, m_eos_next;
    logic          m_eoset_reg, m_eoset_next;
    logic          m_vld_reg, m_vld_next;
    logic          m_trunc_reg, m_trunc_next;

    // Combinational helpers
    logic          accept;
    logic          new_set, keep, store, ends;
    logic [CW-1:0] cnt_e, cnt_n;
    logic [LW-1:0] pos_e, pos_1;
    logic [LW-1:0] n_min;
    logic          ch_diff, last_i, cmp_done, gt;
    logic          last_char, last_str;

    assign s_ready = (state_reg == ST_IDLE) && !pend_reg && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    assign m_valid             = m_valid_reg;
    assign m_out_char          = m_char_reg;
    assign m_out_end_of_string = m_eos_reg;
    assign m_out_end_of_set    = m_eoset_reg;
    assign m_valid_res         = m_vld_reg;
    assign m_truncated         = m_trunc_reg;

    // Push bookkeeping: a push after sorting opens a new set
    assign new_set = (phase_reg != PH_LOADING);
    assign cnt_e   = new_set ? '0 : cnt_reg;
    assign pos_e   = new_set ? '0 : pos_reg;
    assign keep    = (cnt_e < MAX_CNT);
    assign store   = keep && (pos_e < MAX_POS);
    assign pos_1   = store ? pos_e + LW'(1) : pos_e;
    assign ends    = s_end_of_string || s_end_of_set;
    assign cnt_n   = (ends && keep) ? cnt_e + CW'(1) : cnt_e;

    // Neighbor compare on the current character pair
    assign n_min    = (lena_q_reg < lenb_q_reg) ? lena_q_reg : lenb_q_reg;
    assign ch_diff  = (cha_q_reg != chb_q_reg);
    assign last_i   = ({1'b0, i_reg} + (LW+1)'(1)) >= {1'b0, n_min};
    assign cmp_done = ch_diff || last_i;
    assign gt       = ch_diff ? (cha_q_reg > chb_q_reg) : (lena_q_reg > lenb_q_reg);

    // Read position marks
    assign last_char = ({1'b0, rc_reg} + (LW+1)'(1)) >= {1'b0, lena_q_reg};
    assign last_str  = ((CW+1)'(rs_reg) + (CW+1)'(1)) >= (CW+1)'(cnt_reg);

    // Next-state logic
    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        cnt_next        = cnt_reg;
        pos_next        = pos_reg;
        ovf_next        = ovf_reg;
        rs_next         = rs_reg;
        rc_next         = rc_reg;
        pass_next       = pass_reg;
        j_next          = j_reg;
        cur_next        = cur_reg;
        nxt_next        = nxt_reg;
        i_next          = i_reg;
        str_next        = str_reg;
        pend_next       = 1'b0;
        pend_eos_next   = pend_eos_reg;
        pend_eoset_next = pend_eoset_reg;
        pend_vld_next   = pend_vld_reg;
        pend_trunc_next = pend_trunc_reg;
        m_valid_next    = m_valid_reg;
        m_char_next     = m_char_reg;
        m_eos_next      = m_eos_reg;
        m_eoset_next    = m_eoset_reg;
        m_vld_next      = m_vld_reg;
        m_trunc_next    = m_trunc_reg;

        char_we      = 1'b0;
        char_waddr   = {cnt_e[SW-1:0], pos_e};
        char_wdata   = s_char_code;
        char_ra_en   = 1'b0;
        char_ra_addr = {str_reg, rc_reg};
        char_rb_en   = 1'b0;
        char_rb_addr = {nxt_reg, i_reg};
        len_we       = 1'b0;
        len_waddr    = cnt_e[SW-1:0];
        len_wdata    = pos_1;
        len_ra_en    = 1'b0;
        len_ra_addr  = cur_reg;
        len_rb_en    = 1'b0;
        len_rb_addr  = nxt_reg;
        ord_we       = 1'b0;
        ord_waddr    = cnt_e[SW-1:0];
        ord_wdata    = cnt_e[SW-1:0];
        ord_re       = 1'b0;
        ord_raddr    = rs_reg;

        // Drain the output register
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // Load the output register once the character read lands
        if (pend_reg) begin
            m_valid_next = 1'b1;
            m_char_next  = pend_vld_reg ? cha_q_reg : '0;
            m_eos_next   = pend_eos_reg;
            m_eoset_next = pend_eoset_reg;
            m_vld_next   = pend_vld_reg;
            m_trunc_next = pend_trunc_reg;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_operation == sbs_pkg::OP_PUSH) begin
                    if (new_set) begin
                        rs_next = '0;
                        rc_next = '0;
                    end
                    char_we  = store;
                    ovf_next = (new_set ? 1'b0 : ovf_reg) | !store;
                    pos_next = ends ? '0 : pos_1;
                    cnt_next = cnt_n;
                    if (ends && keep) begin
                        len_we = 1'b1;
                        ord_we = 1'b1;
                    end
                    if (s_end_of_set) begin
                        rs_next   = '0;
                        rc_next   = '0;
                        pass_next = '0;
                        if (cnt_n == '0) begin
                            phase_next = PH_DONE;
                        end else begin
                            // A lone string skips the sort; the fetch reads its entry later
                            phase_next = PH_SORTED;
                            state_next = (cnt_n >= CW'(2)) ? ST_PASS : ST_FETCH;
                        end
                    end else begin
                        phase_next = PH_LOADING;
                    end
                end else if (accept) begin
                    pend_next       = 1'b1;
                    pend_trunc_next = ovf_reg;
                    if (phase_reg == PH_SORTED) begin
                        char_ra_en      = 1'b1;
                        char_ra_addr    = {str_reg, rc_reg};
                        pend_vld_next   = 1'b1;
                        pend_eos_next   = last_char;
                        pend_eoset_next = last_char && last_str;
                        if (last_char) begin
                            rc_next = '0;
                            rs_next = rs_reg + SW'(1);
                            if (last_str) begin
                                phase_next = PH_DONE;
                            end else begin
                                ord_re     = 1'b1;
                                ord_raddr  = rs_reg + SW'(1);
                                state_next = ST_FETCH;
                            end
                        end else begin
                            rc_next = rc_reg + LW'(1);
                        end
                    end else begin
                        pend_vld_next   = 1'b0;
                        pend_eos_next   = 1'b0;
                        pend_eoset_next = 1'b0;
                    end
                end
            end

            // Open a pass: fetch the first entry of the order table
            ST_PASS: begin
                ord_re     = 1'b1;
                ord_raddr  = '0;
                j_next     = '0;
                state_next = ST_CUR;
            end

            ST_CUR: begin
                cur_next   = ord_q_reg;
                ord_re     = 1'b1;
                ord_raddr  = j_reg + SW'(1);
                state_next = ST_LENS;
            end

            ST_NXT: begin
                ord_re     = 1'b1;
                ord_raddr  = j_reg + SW'(1);
                state_next = ST_LENS;
            end

            // Fetch lengths and first characters of both neighbors
            ST_LENS: begin
                nxt_next     = ord_q_reg;
                len_ra_en    = 1'b1;
                len_ra_addr  = cur_reg;
                len_rb_en    = 1'b1;
                len_rb_addr  = ord_q_reg;
                char_ra_en   = 1'b1;
                char_ra_addr = {cur_reg, {LW{1'b0}}};
                char_rb_en   = 1'b1;
                char_rb_addr = {ord_q_reg, {LW{1'b0}}};
                i_next       = '0;
                state_next   = ST_CMP;
            end

            // Walk the common prefix; carry the larger string to the right
            ST_CMP: begin
                if (cmp_done) begin
                    ord_we    = 1'b1;
                    ord_waddr = j_reg;
                    ord_wdata = gt ? nxt_reg : cur_reg;
                    cur_next  = gt ? cur_reg : nxt_reg;
                    if ((CW+1)'(j_reg) + (CW+1)'(pass_reg) + (CW+1)'(2) == (CW+1)'(cnt_reg))
                    begin
                        state_next = ST_TAIL;
                    end else begin
                        j_next     = j_reg + SW'(1);
                        state_next = ST_NXT;
                    end
                end else begin
                    i_next       = i_reg + LW'(1);
                    char_ra_en   = 1'b1;
                    char_ra_addr = {cur_reg, i_reg + LW'(1)};
                    char_rb_en   = 1'b1;
                    char_rb_addr = {nxt_reg, i_reg + LW'(1)};
                end
            end

            // Drop the carried string into the last slot of the pass
            ST_TAIL: begin
                ord_we    = 1'b1;
                ord_waddr = j_reg + SW'(1);
                ord_wdata = cur_reg;
                if ((CW+1)'(pass_reg) + (CW+1)'(2) >= (CW+1)'(cnt_reg)) begin
                    state_next = ST_FETCH;
                    ord_re     = 1'b0;
                end else begin
                    pass_next  = pass_reg + SW'(1);
                    state_next = ST_PASS;
                end
            end

            // Load the string index and length for the next read
            ST_FETCH: begin
                state_next = ST_IDLE;
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Order memory read for fetch after the sort is issued from a separate step
    logic fetch_ord_reg;
    logic fetch_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_LOADING;
            cnt_reg        <= '0;
            pos_reg        <= '0;
            ovf_reg        <= 1'b0;
            rs_reg         <= '0;
            rc_reg         <= '0;
            pend_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
            fetch_ord_reg  <= 1'b0;
            fetch_len_reg  <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            pos_reg     <= pos_next;
            ovf_reg     <= ovf_next;
            rs_reg      <= rs_next;
            rc_reg      <= rc_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            // Fetch sequence: order read, then length read, then idle
            if (state_next == ST_FETCH && state_reg != ST_FETCH) begin
                state_reg     <= ST_FETCH;
                fetch_ord_reg <= ord_re;
                fetch_len_reg <= 1'b0;
            end else if (state_reg == ST_FETCH) begin
                if (!fetch_ord_reg) begin
                    fetch_ord_reg <= 1'b1;
                    state_reg     <= ST_FETCH;
                end else if (!fetch_len_reg) begin
                    fetch_len_reg <= 1'b1;
                    state_reg     <= ST_FETCH;
                end else begin
                    fetch_ord_reg <= 1'b0;
                    fetch_len_reg <= 1'b0;
                    state_reg     <= ST_IDLE;
                end
            end else begin
                state_reg <= state_next;
            end
        end
    end

    // Payload and working registers
    always_ff @(posedge aclk) begin
        pass_reg       <= pass_next;
        j_reg          <= j_next;
        cur_reg        <= cur_next;
        nxt_reg        <= nxt_next;
        i_reg          <= i_next;
        pend_eos_reg   <= pend_eos_next;
        pend_eoset_reg <= pend_eoset_next;
        pend_vld_reg   <= pend_vld_next;
        pend_trunc_reg <= pend_trunc_next;
        m_char_reg     <= m_char_next;
        m_eos_reg      <= m_eos_next;
        m_eoset_reg    <= m_eoset_next;
        m_vld_reg      <= m_vld_next;
        m_trunc_reg    <= m_trunc_next;
        if (state_reg == ST_FETCH && fetch_ord_reg && !fetch_len_reg) begin
            str_reg <= ord_q_reg;
        end else begin
            str_reg <= str_next;
        end
    end

    // Character store: one write, two reads
    always_ff @(posedge aclk) begin
        if (char_we) begin
            char_mem[char_waddr] <= char_wdata;
        end
        if (char_ra_en) begin
            cha_q_reg <= char_mem[char_ra_addr];
        end
        if (char_rb_en) begin
            chb_q_reg <= char_mem[char_rb_addr];
        end
    end

    // Length store: one write, two reads; port A also serves the fetch
    always_ff @(posedge aclk) begin
        if (len_we) begin
            len_mem[len_waddr] <= len_wdata;
        end
        if (len_ra_en) begin
            lena_q_reg <= len_mem[len_ra_addr];
        end else if (state_reg == ST_FETCH && fetch_ord_reg && !fetch_len_reg) begin
            lena_q_reg <= len_mem[ord_q_reg];
        end
        if (len_rb_en) begin
            lenb_q_reg <= len_mem[len_rb_addr];
        end
    end

    // Order table: one write, one read; the fetch reads the entry for the next string
    always_ff @(posedge aclk) begin
        if (ord_we) begin
            ord_mem[ord_waddr] <= ord_wdata;
        end
        if (ord_re) begin
            ord_q_reg <= ord_mem[ord_raddr];
        end else if (state_reg == ST_FETCH && !fetch_ord_reg) begin
            ord_q_reg <= ord_mem[rs_reg];
        end
    end

endmodule
